FILE: rtl/pdfu_pkg.sv
// ----------------------------------------------------------------------------
// pdfu_pkg
// Shared types, constants and fixed-point helpers for the particle update.
// ----------------------------------------------------------------------------
package pdfu_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int Q_W        = 24;
    localparam int ALPHA_W    = 17;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int ONE_Q   = 1 << FRAC_BITS;
    localparam int STEP_DZ = (ONE_Q + 50) / 100;
    localparam int STEP_A  = (ONE_Q + 250) / 500;

    // exact reciprocal multipliers for 24-bit unsigned operands
    localparam logic [31:0] DIV10_MUL    = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT  = 35;
    localparam logic [31:0] DIV100_MUL   = 32'd1374389535;
    localparam int          DIV100_SHIFT = 37;

    localparam logic [0:0] REG_ORIGIN_Z     = 1'b0;
    localparam logic [0:0] REG_FLOOR_OFFSET = 1'b1;

    typedef logic signed [Q_W-1:0]  q24_t;
    typedef logic signed [Q_W:0]    q25_t;
    typedef logic [ALPHA_W-1:0]     alpha_t;

    typedef struct packed {
        q24_t   pos_x;
        q24_t   pos_y;
        q24_t   pos_z;
        q24_t   dir_x;
        q24_t   dir_y;
        q24_t   dir_z;
        alpha_t alpha_in;
        logic   last_in;
    } particle_t;

    typedef struct packed {
        q24_t   new_pos_x;
        q24_t   new_pos_y;
        q24_t   new_pos_z;
        q24_t   new_dir_x;
        q24_t   new_dir_y;
        q24_t   new_dir_z;
        alpha_t alpha_out;
        logic   last_out;
        logic   all_faded;
    } update_t;

    typedef struct packed {
        q24_t origin_z;
        q24_t floor_offset;
    } cfg_t;

    function automatic logic [Q_W-1:0] mag24(input q24_t v);
        logic [Q_W-1:0] u;
        u = v[Q_W-1] ? (~v + 24'd1) : v;
        return u;
    endfunction

    function automatic logic [Q_W-1:0] div10(input logic [Q_W-1:0] a);
        logic [55:0] p;
        p = {32'd0, a} * {24'd0, DIV10_MUL};
        return 24'(p[55:DIV10_SHIFT]);
    endfunction

    function automatic logic [Q_W-1:0] div100(input logic [Q_W-1:0] a);
        logic [55:0] p;
        p = {32'd0, a} * {24'd0, DIV100_MUL};
        return 24'(p[55:DIV100_SHIFT]);
    endfunction

    // signed quotient by ten, truncated toward zero
    function automatic q24_t sdiv10(input q24_t v);
        logic [Q_W-1:0] q;
        q = div10(mag24(v));
        return v[Q_W-1] ? q24_t'(~q + 24'd1) : q24_t'(q);
    endfunction

    function automatic q24_t sat24(input q25_t v);
        q24_t r;
        if (v > 25'sd8388607)
            r = 24'sh7F_FFFF;
        else if (v < -25'sd8388608)
            r = 24'sh80_0000;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    function automatic q25_t sx25(input q24_t v);
        return {v[Q_W-1], v};
    endfunction

endpackage

FILE: rtl/pdfu_stream_if.sv
// ----------------------------------------------------------------------------
// pdfu_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface pdfu_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/pdfu_cfg_regs.sv
// ----------------------------------------------------------------------------
// pdfu_cfg_regs
// APB register file holding the origin z and floor offset.
// ----------------------------------------------------------------------------
module pdfu_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdfu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pdfu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pdfu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output pdfu_pkg::cfg_t                   cfg
);

    pdfu_pkg::q24_t origin_z_reg;
    pdfu_pkg::q24_t floor_offset_reg;
    logic           wr_en;
    logic [0:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_z_reg     <= '0;
            floor_offset_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pdfu_pkg::REG_ORIGIN_Z:     origin_z_reg     <= pwdata[23:0];
                pdfu_pkg::REG_FLOOR_OFFSET: floor_offset_reg <= pwdata[23:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pdfu_pkg::REG_ORIGIN_Z:     prdata = 32'(signed'(origin_z_reg));
            pdfu_pkg::REG_FLOOR_OFFSET: prdata = 32'(signed'(floor_offset_reg));
            default:                    prdata = '0;
        endcase
    end

    assign cfg.origin_z     = origin_z_reg;
    assign cfg.floor_offset = floor_offset_reg;

endmodule

FILE: rtl/pdfu_update.sv
// ----------------------------------------------------------------------------
// pdfu_update
// One particle step: drift and damping when airborne, alpha fade otherwise.
// ----------------------------------------------------------------------------
module pdfu_update (
    input  pdfu_pkg::particle_t p,
    input  pdfu_pkg::cfg_t      cfg,
    output pdfu_pkg::update_t   r
);

    pdfu_pkg::q25_t   floor_lvl;
    logic             airborne;
    pdfu_pkg::q24_t   qx, qy, qz;
    logic [23:0]      amt_x, amt_y;
    pdfu_pkg::q24_t   dx_new, dy_new, dz_new;
    pdfu_pkg::q25_t   dz25, dz_up, dz_dn, dz_res;
    pdfu_pkg::q25_t   one25, step25;
    pdfu_pkg::alpha_t alpha_new;

    assign floor_lvl = pdfu_pkg::sx25(cfg.floor_offset) - pdfu_pkg::sx25(cfg.origin_z);
    assign airborne  = pdfu_pkg::sx25(p.pos_z) >= floor_lvl;

    assign qx = pdfu_pkg::sdiv10(p.dir_x);
    assign qy = pdfu_pkg::sdiv10(p.dir_y);
    assign qz = pdfu_pkg::sdiv10(p.dir_z);

    assign amt_x  = pdfu_pkg::div100(pdfu_pkg::mag24(p.dir_x));
    assign amt_y  = pdfu_pkg::div100(pdfu_pkg::mag24(p.dir_y));
    assign dx_new = p.dir_x[23] ? p.dir_x + $signed(amt_x) : p.dir_x - $signed(amt_x);
    assign dy_new = p.dir_y[23] ? p.dir_y + $signed(amt_y) : p.dir_y - $signed(amt_y);

    assign one25  = 25'(pdfu_pkg::ONE_Q);
    assign step25 = 25'(pdfu_pkg::STEP_DZ);
    assign dz25   = pdfu_pkg::sx25(p.dir_z);
    assign dz_up  = dz25 + step25;
    assign dz_dn  = dz25 - step25;

    always_comb
    begin
        if (dz25 < one25)
            dz_res = (dz_up < one25) ? dz_up : one25;
        else if (dz25 > one25)
            dz_res = (dz_dn > one25) ? dz_dn : one25;
        else
            dz_res = one25;
    end

    assign dz_new = dz_res[23:0];

    assign alpha_new = (p.alpha_in > 17'(pdfu_pkg::STEP_A))
                     ? p.alpha_in - 17'(pdfu_pkg::STEP_A) : '0;

    always_comb
    begin
        r.last_out  = p.last_in;
        r.all_faded = 1'b0;
        if (airborne)
        begin
            r.new_pos_x = pdfu_pkg::sat24(pdfu_pkg::sx25(p.pos_x) - pdfu_pkg::sx25(qx));
            r.new_pos_y = pdfu_pkg::sat24(pdfu_pkg::sx25(p.pos_y) - pdfu_pkg::sx25(qy));
            r.new_pos_z = pdfu_pkg::sat24(pdfu_pkg::sx25(p.pos_z) - pdfu_pkg::sx25(qz));
            r.new_dir_x = dx_new;
            r.new_dir_y = dy_new;
            r.new_dir_z = dz_new;
            r.alpha_out = p.alpha_in;
        end
        else
        begin
            r.new_pos_x = p.pos_x;
            r.new_pos_y = p.pos_y;
            r.new_pos_z = p.pos_z;
            r.new_dir_x = p.dir_x;
            r.new_dir_y = p.dir_y;
            r.new_dir_z = p.dir_z;
            r.alpha_out = alpha_new;
        end
    end

endmodule

FILE: rtl/particle_drift_fade_update.sv
// ----------------------------------------------------------------------------
// particle_drift_fade_update
// Streams particle records through one update step and tracks the fade-out.
//
// The particle channel takes one record per item; the update channel returns
// one result per item, in order. Both are valid/ready; an item moves when
// valid and ready are high at a rising edge of clk.
// A result is valid once its record has passed the input register and the
// result register. Throughput: one item per cycle while the receiver keeps
// ready high, set by an input register and a result register with the update
// logic between them; ready is high while the input register is empty or can
// pass its item on.
// When the receiver stalls, the result register holds and the input register
// still takes one more item before ready falls.
// The APB port sets origin_z (0x0) and floor_offset (0x4); write them only
// while no item is in flight. all_faded is raised on the result marked last
// when every alpha of the pass is zero; the pass tracking then restarts.
// Reset (rst_n low) empties both registers, clears the configuration to zero
// and restarts the pass tracking.
// ----------------------------------------------------------------------------
module particle_drift_fade_update (
    input  logic                             clk,
    input  logic                             rst_n,
    pdfu_stream_if.sink                      particle,
    pdfu_stream_if.source                    update,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdfu_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pdfu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pdfu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    pdfu_pkg::cfg_t      cfg;
    pdfu_pkg::particle_t s1_item_reg;
    logic                s1_valid_reg, s1_valid_next;
    pdfu_pkg::update_t   s2_item_reg, s2_item_next;
    logic                s2_valid_reg, s2_valid_next;
    logic                azsf_reg, azsf_next;
    pdfu_pkg::update_t   res;
    logic                adv2, load2, accept_in, done;

    pdfu_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdfu_update u_update (
        .p   (s1_item_reg),
        .cfg (cfg),
        .r   (res)
    );

    assign adv2           = !s2_valid_reg || update.ready;
    assign load2          = s1_valid_reg && adv2;
    assign particle.ready = !s1_valid_reg || adv2;
    assign accept_in      = particle.valid && particle.ready;
    assign done           = azsf_reg && (res.alpha_out == '0);

    always_comb
    begin
        s1_valid_next = accept_in ? 1'b1 : (adv2 ? 1'b0 : s1_valid_reg);
        s2_valid_next = load2 ? 1'b1 : (update.ready ? 1'b0 : s2_valid_reg);
        azsf_next     = azsf_reg;
        if (load2)
        begin
            azsf_next = res.last_out ? 1'b1 : done;
        end
        s2_item_next           = res;
        s2_item_next.all_faded = res.last_out && done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            azsf_reg     <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            azsf_reg     <= azsf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            s1_item_reg <= particle.payload;
        end
        if (load2)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign update.valid   = s2_valid_reg;
    assign update.payload = s2_item_reg;

`ifndef NO_ASSERTIONS
    a_faded_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        update.valid && update.payload.all_faded |-> update.payload.last_out)
        else $error("all_faded on a result not marked last");

    a_faded_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
        update.valid && update.payload.all_faded |-> update.payload.alpha_out == '0)
        else $error("all_faded with non-zero alpha");

    a_pass_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load2 && s1_item_reg.last_in |=> azsf_reg)
        else $error("pass tracking not restarted after last item");

    a_stage1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv2 |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register lost an item under stall");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |-> !s1_valid_reg || load2)
        else $error("input register overwritten");
`endif

endmodule

FILE: tb/particle_drift_fade_update_tb.sv
// ----------------------------------------------------------------------------
// particle_drift_fade_update_tb
// Streams particle records through the update block under changing floor
// settings and idling patterns. Each accepted record is run through a local
// fixed-point predictor, and every update leaving the block is checked field
// by field, in order, against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module particle_drift_fade_update_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int Q_MAX           = 8388607;
    localparam int Q_MIN           = -8388608;

    localparam logic [pdfu_pkg::APB_ADDR_W-1:0] ADDR_ORIGIN_Z =
        pdfu_pkg::APB_ADDR_W'(4 * int'(pdfu_pkg::REG_ORIGIN_Z));
    localparam logic [pdfu_pkg::APB_ADDR_W-1:0] ADDR_FLOOR_OFFSET =
        pdfu_pkg::APB_ADDR_W'(4 * int'(pdfu_pkg::REG_FLOOR_OFFSET));

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pdfu_pkg::APB_ADDR_W-1:0] paddr;
    logic [pdfu_pkg::APB_DATA_W-1:0] pwdata;
    logic [pdfu_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    pdfu_stream_if #(.payload_t(pdfu_pkg::particle_t)) particle_ch ();
    pdfu_stream_if #(.payload_t(pdfu_pkg::update_t))   update_ch ();

    particle_drift_fade_update dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .particle (particle_ch),
        .update   (update_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pdfu_pkg::particle_t particle_backlog[$];
    pdfu_pkg::update_t   expected_updates[$];

    pdfu_pkg::q24_t cfg_origin_z;
    pdfu_pkg::q24_t cfg_floor_offset;
    logic pass_all_zero;
    logic particle_taken;
    logic rx_hold;
    logic hold_go;
    int   tx_idle_pct;
    int   rx_stall_pct;
    int   idle_cycles;
    int   mismatch_count;
    int   updates_checked;
    int   grounded_count;
    int   faded_passes;
    int   settings_count;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic pdfu_pkg::q24_t clamp24(input int v);
        pdfu_pkg::q24_t r;
        if (v > Q_MAX)
            r = pdfu_pkg::q24_t'(Q_MAX);
        else if (v < Q_MIN)
            r = pdfu_pkg::q24_t'(Q_MIN);
        else
            r = pdfu_pkg::q24_t'(v);
        return r;
    endfunction

    function automatic int step_toward(input int from, input int to, input int amt);
        int r;
        if (from < to)
            r = (from + amt < to) ? from + amt : to;
        else if (from > to)
            r = (from - amt > to) ? from - amt : to;
        else
            r = to;
        return r;
    endfunction

    function automatic pdfu_pkg::update_t predict_update(input pdfu_pkg::particle_t p);
        int                px;
        int                py;
        int                pz;
        int                dx;
        int                dy;
        int                dz;
        int                alpha;
        logic              cleared;
        pdfu_pkg::update_t r;
        px    = int'(p.pos_x);
        py    = int'(p.pos_y);
        pz    = int'(p.pos_z);
        dx    = int'(p.dir_x);
        dy    = int'(p.dir_y);
        dz    = int'(p.dir_z);
        alpha = int'(p.alpha_in);
        if (pz >= int'(cfg_floor_offset) - int'(cfg_origin_z))
        begin
            px = int'(clamp24(px - dx / 10));
            py = int'(clamp24(py - dy / 10));
            pz = int'(clamp24(pz - dz / 10));
            dx = step_toward(dx, 0, ((dx < 0) ? -dx : dx) / 100);
            dy = step_toward(dy, 0, ((dy < 0) ? -dy : dy) / 100);
            dz = step_toward(dz, pdfu_pkg::ONE_Q, pdfu_pkg::STEP_DZ);
        end
        else
        begin
            alpha = step_toward(alpha, 0, pdfu_pkg::STEP_A);
            grounded_count++;
        end
        cleared       = pass_all_zero && (alpha == 0);
        r.new_pos_x   = pdfu_pkg::q24_t'(px);
        r.new_pos_y   = pdfu_pkg::q24_t'(py);
        r.new_pos_z   = pdfu_pkg::q24_t'(pz);
        r.new_dir_x   = pdfu_pkg::q24_t'(dx);
        r.new_dir_y   = pdfu_pkg::q24_t'(dy);
        r.new_dir_z   = pdfu_pkg::q24_t'(dz);
        r.alpha_out   = pdfu_pkg::alpha_t'(alpha);
        r.last_out    = p.last_in;
        r.all_faded   = p.last_in && cleared;
        if (r.all_faded)
            faded_passes++;
        pass_all_zero = p.last_in ? 1'b1 : cleared;
        return r;
    endfunction

    function automatic pdfu_pkg::q24_t pick_q24();
        pdfu_pkg::q24_t v;
        case ($urandom_range(9))
            0: v = pdfu_pkg::q24_t'(Q_MAX);
            1: v = pdfu_pkg::q24_t'(Q_MIN);
            2: v = pdfu_pkg::q24_t'(int'($urandom_range(200)) - 100);
            3: v = pdfu_pkg::q24_t'(int'($urandom_range(2000)) - 1000);
            default: v = pdfu_pkg::q24_t'($urandom);
        endcase
        return v;
    endfunction

    function automatic pdfu_pkg::particle_t random_particle(input bit fading);
        pdfu_pkg::particle_t p;
        int                  thr;
        thr     = int'(cfg_floor_offset) - int'(cfg_origin_z);
        p.pos_x = pick_q24();
        p.pos_y = pick_q24();
        p.dir_x = pick_q24();
        p.dir_y = pick_q24();
        if ($urandom_range(3) == 0)
            p.dir_z = clamp24(pdfu_pkg::ONE_Q + int'($urandom_range(1400)) - 700);
        else
            p.dir_z = pick_q24();
        if (fading && thr > Q_MIN)
        begin
            p.pos_z = clamp24(thr - 1 - int'($urandom_range(70000)));
            if ($urandom_range(7) == 0)
                p.alpha_in = pdfu_pkg::alpha_t'($urandom_range(400, 132));
            else
                p.alpha_in = pdfu_pkg::alpha_t'($urandom_range(131));
        end
        else if (fading)
        begin
            p.pos_z    = pick_q24();
            p.alpha_in = '0;
        end
        else
        begin
            case ($urandom_range(3))
                0, 1: p.pos_z = pick_q24();
                2: p.pos_z = clamp24(thr + int'($urandom_range(6)) - 3);
                default: p.pos_z = clamp24(thr + int'($urandom_range(131072)) - 65536);
            endcase
            case ($urandom_range(3))
                0: p.alpha_in = pdfu_pkg::alpha_t'($urandom);
                1: p.alpha_in = pdfu_pkg::alpha_t'($urandom_range(pdfu_pkg::ONE_Q));
                2: p.alpha_in = pdfu_pkg::alpha_t'($urandom_range(300));
                default: p.alpha_in = ($urandom_range(1) != 0)
                                    ? pdfu_pkg::alpha_t'(pdfu_pkg::ONE_Q) : '0;
            endcase
        end
        p.last_in = 1'b0;
        return p;
    endfunction

    task automatic push_particle(input int px, input int py, input int pz,
                                 input int dx, input int dy, input int dz,
                                 input int alpha, input logic last);
        pdfu_pkg::particle_t p;
        p.pos_x    = pdfu_pkg::q24_t'(px);
        p.pos_y    = pdfu_pkg::q24_t'(py);
        p.pos_z    = pdfu_pkg::q24_t'(pz);
        p.dir_x    = pdfu_pkg::q24_t'(dx);
        p.dir_y    = pdfu_pkg::q24_t'(dy);
        p.dir_z    = pdfu_pkg::q24_t'(dz);
        p.alpha_in = pdfu_pkg::alpha_t'(alpha);
        p.last_in  = last;
        particle_backlog.insert(particle_backlog.size(), p);
    endtask

    task automatic apb_write(input logic [0:0] reg_sel, input pdfu_pkg::q24_t value);
        logic [pdfu_pkg::APB_ADDR_W-1:0] addr;
        addr = (reg_sel == pdfu_pkg::REG_ORIGIN_Z) ? ADDR_ORIGIN_Z : ADDR_FLOOR_OFFSET;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= pdfu_pkg::APB_DATA_W'(signed'(value));
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_sel == pdfu_pkg::REG_ORIGIN_Z)
            cfg_origin_z = value;
        else
            cfg_floor_offset = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (pdfu_pkg::q24_t'(prdata[pdfu_pkg::Q_W-1:0]) !== value)
            report_mismatch("register readback",
                            signed'(pdfu_pkg::q24_t'(prdata[pdfu_pkg::Q_W-1:0])), value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (particle_backlog.size() != 0 || particle_ch.valid ||
               expected_updates.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_directed();
        int qmax;
        int qmin;
        int one;
        qmax = Q_MAX;
        qmin = Q_MIN;
        one  = pdfu_pkg::ONE_Q;
        push_particle(qmax, qmin, qmax, qmin, qmax, qmin, pdfu_pkg::ONE_Q, 1'b0);
        push_particle(0, 0, 0, 99, -100, one + 100, 0, 1'b0);
        push_particle(5, -5, 0, 101, -99, one - 100, 0, 1'b1);
        push_particle(1, 2, -1, 300, -300, 7, 131, 1'b0);
        push_particle(-1, -2, qmin, qmin, qmax, qmin, 0, 1'b0);
        push_particle(0, 0, 1, 0, 0, one, 0, 1'b1);
        push_particle(3, 3, -1, 3, 3, 3, 1, 1'b1);
        push_particle(0, 0, -1, 0, 0, 0, 132, 1'b1);
        push_particle(qmax, qmax, -65536, qmax, qmax, qmax, 131071, 1'b0);
        push_particle(0, 0, qmax, 0, 0, 0, 100000, 1'b1);
        push_particle(0, 0, 0, qmax, qmin, qmax, 0, 1'b0);
        push_particle(qmin, qmax, qmax, 9, -9, qmin, 0, 1'b0);
        push_particle(qmin, qmin, qmin, -9, 9, one, pdfu_pkg::ONE_Q, 1'b0);
        push_particle(qmin, qmax, 0, -10, 10, one + 655, 65535, 1'b0);
        push_particle(qmax, qmin, 0, 10, -10, one - 654, 131, 1'b1);
        push_particle(0, 0, 0, 0, 0, 0, 0, 1'b0);
        push_particle(qmin, qmin, -1, qmin, qmin, qmin, 0, 1'b1);
        push_particle(-1, -1, -1, -1, -1, -1, 131071, 1'b1);
    endtask

    task automatic load_random_passes();
        int                  n;
        int                  len;
        bit                  fading;
        bit                  noisy;
        pdfu_pkg::particle_t p;
        n = 0;
        while (n < ITEMS_PER_PHASE)
        begin
            len    = $urandom_range(12, 1);
            fading = ($urandom_range(3) == 0);
            noisy  = ($urandom_range(6) == 0);
            for (int k = 0; k < len; k++)
            begin
                p         = random_particle(fading);
                p.last_in = noisy ? logic'($urandom_range(1)) : (k == len - 1);
                particle_backlog.insert(particle_backlog.size(), p);
                n++;
            end
        end
    endtask

    // hold the receiver off for a long stretch so that the block backs up
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            particle_ch.valid <= 1'b0;
        else if (!particle_ch.valid || particle_taken)
        begin
            if (particle_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                particle_ch.valid   <= 1'b1;
                particle_ch.payload <= particle_backlog.pop_front();
            end
            else
                particle_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            update_ch.ready <= 1'b0;
        else
            update_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        pdfu_pkg::update_t got;
        pdfu_pkg::update_t want;
        particle_taken = rst_n && particle_ch.valid && particle_ch.ready;
        if (rst_n && update_ch.valid && update_ch.ready)
        begin
            got = update_ch.payload;
            if (expected_updates.size() == 0)
                report_mismatch("unexpected item, new_pos_x", got.new_pos_x, 0);
            else
            begin
                want = expected_updates.pop_front();
                updates_checked++;
                if (got.new_pos_x !== want.new_pos_x)
                    report_mismatch("new_pos_x", got.new_pos_x, want.new_pos_x);
                if (got.new_pos_y !== want.new_pos_y)
                    report_mismatch("new_pos_y", got.new_pos_y, want.new_pos_y);
                if (got.new_pos_z !== want.new_pos_z)
                    report_mismatch("new_pos_z", got.new_pos_z, want.new_pos_z);
                if (got.new_dir_x !== want.new_dir_x)
                    report_mismatch("new_dir_x", got.new_dir_x, want.new_dir_x);
                if (got.new_dir_y !== want.new_dir_y)
                    report_mismatch("new_dir_y", got.new_dir_y, want.new_dir_y);
                if (got.new_dir_z !== want.new_dir_z)
                    report_mismatch("new_dir_z", got.new_dir_z, want.new_dir_z);
                if (got.alpha_out !== want.alpha_out)
                    report_mismatch("alpha_out", got.alpha_out, want.alpha_out);
                if (got.last_out !== want.last_out)
                    report_mismatch("last_out", got.last_out, want.last_out);
                if (got.all_faded !== want.all_faded)
                    report_mismatch("all_faded", got.all_faded, want.all_faded);
            end
        end
        if (particle_taken)
            expected_updates.insert(expected_updates.size(),
                                    predict_update(particle_ch.payload));
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (particle_ch.valid && particle_ch.ready) ||
            (update_ch.valid && update_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        pdfu_pkg::q24_t origin;
        pdfu_pkg::q24_t floor_lvl;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        particle_ch.valid   = 1'b0;
        particle_ch.payload = '0;
        update_ch.ready     = 1'b0;
        cfg_origin_z        = '0;
        cfg_floor_offset    = '0;
        pass_all_zero       = 1'b1;
        particle_taken      = 1'b0;
        hold_go             = 1'b0;
        tx_idle_pct         = 0;
        rx_stall_pct        = 0;
        idle_cycles         = 0;
        mismatch_count      = 0;
        updates_checked     = 0;
        grounded_count      = 0;
        faded_passes        = 0;
        settings_count      = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin origin = '0; floor_lvl = '0; end
                1:
                begin
                    origin    = pdfu_pkg::q24_t'(Q_MIN);
                    floor_lvl = pdfu_pkg::q24_t'(Q_MAX);
                end
                2:
                begin
                    origin    = pdfu_pkg::q24_t'(Q_MAX);
                    floor_lvl = pdfu_pkg::q24_t'(Q_MIN);
                end
                3:
                begin
                    origin    = pdfu_pkg::q24_t'(int'($urandom_range(2097152)) - 1048576);
                    floor_lvl = pdfu_pkg::q24_t'(int'($urandom_range(2097152)) - 1048576);
                end
                4: begin origin = pdfu_pkg::q24_t'(pdfu_pkg::ONE_Q); floor_lvl = '0; end
                5:
                begin
                    origin    = pdfu_pkg::q24_t'(Q_MAX);
                    floor_lvl = pdfu_pkg::q24_t'(Q_MAX);
                end
                6:
                begin
                    origin    = pdfu_pkg::q24_t'(Q_MIN);
                    floor_lvl = pdfu_pkg::q24_t'(Q_MIN);
                end
                default:
                begin
                    origin    = pdfu_pkg::q24_t'($urandom);
                    floor_lvl = pdfu_pkg::q24_t'($urandom);
                end
            endcase
            apb_write(pdfu_pkg::REG_ORIGIN_Z, origin);
            apb_write(pdfu_pkg::REG_FLOOR_OFFSET, floor_lvl);
            settings_count++;
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 87; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 87; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            if (phase == 0)
                load_directed();
            load_random_passes();
            if (phase == 4)
                hold_go = 1'b1;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        while (expected_updates.size() != 0)
        begin
            want_leftover();
        end
        $display("covered %0d floor settings and %0d updates:", settings_count,
                 updates_checked);
        $display("%0d grounded, %0d passes faded out", grounded_count, faded_passes);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic want_leftover();
        pdfu_pkg::update_t want;
        want = expected_updates.pop_front();
        report_mismatch("missing item, new_pos_x", 0, want.new_pos_x);
    endtask

endmodule
